// ===== rtl/rhr_pkg.sv =====
// Shared types and constants for the rainbow HSV-to-RGB pixel pipeline.
// No dependencies; used by rhr_hue_stage and rainbow_hsv_to_rgb_top.
`timescale 1ns / 1ps
`default_nettype none

package rhr_pkg;

    localparam int unsigned CHAN_W       = 8;
    localparam int unsigned CFG_INDEX_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_SATURATION = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS = 2'd1;

    localparam logic [CHAN_W-1:0] SATURATION_RESET = 8'd255;
    localparam logic [CHAN_W-1:0] BRIGHTNESS_RESET = 8'd120;
    localparam logic [CHAN_W-1:0] CHAN_MAX         = 8'd255;

    // Hue circle is split into six regions; all but the last span this many units.
    localparam logic [CHAN_W-1:0] REGION_SPAN = 8'd43;
    localparam logic [2:0]        FRAC_SCALE  = 3'd6;

    typedef enum logic [2:0] {
        REGION_RED_YELLOW   = 3'd0,
        REGION_YELLOW_GREEN = 3'd1,
        REGION_GREEN_CYAN   = 3'd2,
        REGION_CYAN_BLUE    = 3'd3,
        REGION_BLUE_MAGENTA = 3'd4,
        REGION_MAGENTA_RED  = 3'd5
    } region_t;

    typedef struct packed {
        region_t           region;
        logic [CHAN_W-1:0] frac;
    } hue_info_t;

endpackage

`default_nettype wire

// ===== rtl/rhr_hue_stage.sv =====
// Two-stage hue front end: per-LED hue offset, then hue region and scaled remainder.
// Depends on rhr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rhr_hue_stage #(
    parameter int unsigned STRIP_LEN = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [rhr_pkg::CHAN_W-1:0] step,
    input  wire logic [rhr_pkg::CHAN_W-1:0] led_index,
    output logic                           hue_valid,
    input  wire logic                      hue_ready,
    output rhr_pkg::hue_info_t             hue_info
);

    // offset = floor(led_index * 256 / STRIP_LEN) is computed as
    // (led_index * ceil(2^24 / STRIP_LEN)) >> 16, exact for all 8-bit indexes.
    localparam int unsigned MULT_W = 25;
    localparam logic [MULT_W-1:0] HUE_MULT =
        MULT_W'(((64'd1 << 24) + 64'(STRIP_LEN) - 64'd1) / 64'(STRIP_LEN));
    localparam int unsigned PROD_W = MULT_W + rhr_pkg::CHAN_W;

    logic [PROD_W-1:0]          offset_prod;
    logic [rhr_pkg::CHAN_W-1:0] hue;
    logic [rhr_pkg::CHAN_W-1:0] region_base;
    logic [rhr_pkg::CHAN_W-1:0] frac_next;
    rhr_pkg::region_t           region_next;

    logic                       s1_valid_reg;
    logic [rhr_pkg::CHAN_W-1:0] s1_offset_reg;
    logic [rhr_pkg::CHAN_W-1:0] s1_step_reg;
    logic                       s2_valid_reg;
    rhr_pkg::hue_info_t         s2_info_reg;
    logic                       adv1;
    logic                       adv2;

    assign adv2     = hue_ready || !s2_valid_reg;
    assign adv1     = adv2 || !s1_valid_reg;
    assign in_ready = adv1;

    assign offset_prod = PROD_W'(led_index) * PROD_W'(HUE_MULT);

    always_comb
    begin
        hue = s1_step_reg + s1_offset_reg;
        if (hue < 8'd43)
        begin
            region_next = rhr_pkg::REGION_RED_YELLOW;
            region_base = 8'd0;
        end
        else if (hue < 8'd86)
        begin
            region_next = rhr_pkg::REGION_YELLOW_GREEN;
            region_base = rhr_pkg::REGION_SPAN;
        end
        else if (hue < 8'd129)
        begin
            region_next = rhr_pkg::REGION_GREEN_CYAN;
            region_base = 8'd86;
        end
        else if (hue < 8'd172)
        begin
            region_next = rhr_pkg::REGION_CYAN_BLUE;
            region_base = 8'd129;
        end
        else if (hue < 8'd215)
        begin
            region_next = rhr_pkg::REGION_BLUE_MAGENTA;
            region_base = 8'd172;
        end
        else
        begin
            region_next = rhr_pkg::REGION_MAGENTA_RED;
            region_base = 8'd215;
        end
        // Remainder is at most 42, so the scaled value stays below 256.
        frac_next = 8'((hue - region_base) * 8'(rhr_pkg::FRAC_SCALE));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_offset_reg <= offset_prod[23:16];
            s1_step_reg   <= step;
        end
        if (adv2)
        begin
            s2_info_reg.region <= region_next;
            s2_info_reg.frac   <= frac_next;
        end
    end

    assign hue_valid = s2_valid_reg;
    assign hue_info  = s2_info_reg;

endmodule

`default_nettype wire

// ===== rtl/rainbow_hsv_to_rgb_top.sv =====
// Top level of the rainbow pixel generator: configuration registers and the color stages.
// Depends on rhr_pkg and rhr_hue_stage.
`timescale 1ns / 1ps
`default_nettype none

// Rainbow pixel generator. Each input transaction carries an animation step and an
// LED index; the block forms hue = step + led_index * 256 / STRIP_LEN (mod 256) and
// converts it, with the configured saturation and brightness, to 8-bit green, red and
// blue. The work is a five-stage pipeline (hue offset multiply, hue region, saturation
// products, brightness products, channel select), and one transaction is accepted every
// cycle while the output side keeps up. A stall on the output holds each stage in
// place; no transaction is lost.
// Saturation (index 0, reset 255) and brightness (index 1, reset 120) are written
// through the configuration channel; the user must write them only while no
// transaction is in flight, as the block does not enforce this. Other indexes are ignored.
module rainbow_hsv_to_rgb_top #(
    parameter int unsigned STRIP_LEN = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [rhr_pkg::CHAN_W-1:0]      step,
    input  wire logic [rhr_pkg::CHAN_W-1:0]      led_index,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [rhr_pkg::CHAN_W-1:0]           green,
    output logic [rhr_pkg::CHAN_W-1:0]           red,
    output logic [rhr_pkg::CHAN_W-1:0]           blue,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rhr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [rhr_pkg::CHAN_W-1:0]      cfg_data
);

    localparam int unsigned PROD_W = 2 * rhr_pkg::CHAN_W;

    logic [rhr_pkg::CHAN_W-1:0] saturation_reg;
    logic [rhr_pkg::CHAN_W-1:0] brightness_reg;

    logic                       hue_valid;
    logic                       hue_ready;
    rhr_pkg::hue_info_t         hue_info;

    // Stage 3: saturation terms.
    logic                       s3_valid_reg;
    rhr_pkg::region_t           s3_region_reg;
    logic [rhr_pkg::CHAN_W-1:0] s3_pterm_reg;
    logic [rhr_pkg::CHAN_W-1:0] s3_qterm_reg;
    logic [rhr_pkg::CHAN_W-1:0] s3_tterm_reg;
    // Stage 4: p, q, t.
    logic                       s4_valid_reg;
    rhr_pkg::region_t           s4_region_reg;
    logic [rhr_pkg::CHAN_W-1:0] s4_p_reg;
    logic [rhr_pkg::CHAN_W-1:0] s4_q_reg;
    logic [rhr_pkg::CHAN_W-1:0] s4_t_reg;
    // Stage 5: output register.
    logic                       s5_valid_reg;
    logic [rhr_pkg::CHAN_W-1:0] green_reg;
    logic [rhr_pkg::CHAN_W-1:0] red_reg;
    logic [rhr_pkg::CHAN_W-1:0] blue_reg;

    logic                       adv3;
    logic                       adv4;
    logic                       adv5;

    logic [PROD_W-1:0]          sq_prod;
    logic [PROD_W-1:0]          st_prod;
    logic [PROD_W-1:0]          vp_prod;
    logic [PROD_W-1:0]          vq_prod;
    logic [PROD_W-1:0]          vt_prod;
    logic [rhr_pkg::CHAN_W-1:0] green_next;
    logic [rhr_pkg::CHAN_W-1:0] red_next;
    logic [rhr_pkg::CHAN_W-1:0] blue_next;

    rhr_hue_stage #(
        .STRIP_LEN (STRIP_LEN)
    ) u_hue_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .step      (step),
        .led_index (led_index),
        .hue_valid (hue_valid),
        .hue_ready (hue_ready),
        .hue_info  (hue_info)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saturation_reg <= rhr_pkg::SATURATION_RESET;
            brightness_reg <= rhr_pkg::BRIGHTNESS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rhr_pkg::CFG_SATURATION: saturation_reg <= cfg_data;
                rhr_pkg::CFG_BRIGHTNESS: brightness_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign adv5      = out_ready || !s5_valid_reg;
    assign adv4      = adv5 || !s4_valid_reg;
    assign adv3      = adv4 || !s3_valid_reg;
    assign hue_ready = adv3;

    assign sq_prod = PROD_W'(saturation_reg) * PROD_W'(hue_info.frac);
    assign st_prod = PROD_W'(saturation_reg) * PROD_W'(rhr_pkg::CHAN_MAX - hue_info.frac);
    assign vp_prod = PROD_W'(brightness_reg) * PROD_W'(s3_pterm_reg);
    assign vq_prod = PROD_W'(brightness_reg) * PROD_W'(s3_qterm_reg);
    assign vt_prod = PROD_W'(brightness_reg) * PROD_W'(s3_tterm_reg);

    always_comb
    begin
        if (saturation_reg == '0)
        begin
            green_next = brightness_reg;
            red_next   = brightness_reg;
            blue_next  = brightness_reg;
        end
        else
        begin
            unique case (s4_region_reg)
                rhr_pkg::REGION_RED_YELLOW:
                begin
                    red_next   = brightness_reg;
                    green_next = s4_t_reg;
                    blue_next  = s4_p_reg;
                end
                rhr_pkg::REGION_YELLOW_GREEN:
                begin
                    red_next   = s4_q_reg;
                    green_next = brightness_reg;
                    blue_next  = s4_p_reg;
                end
                rhr_pkg::REGION_GREEN_CYAN:
                begin
                    red_next   = s4_p_reg;
                    green_next = brightness_reg;
                    blue_next  = s4_t_reg;
                end
                rhr_pkg::REGION_CYAN_BLUE:
                begin
                    red_next   = s4_p_reg;
                    green_next = s4_q_reg;
                    blue_next  = brightness_reg;
                end
                rhr_pkg::REGION_BLUE_MAGENTA:
                begin
                    red_next   = s4_t_reg;
                    green_next = s4_p_reg;
                    blue_next  = brightness_reg;
                end
                default:
                begin
                    red_next   = brightness_reg;
                    green_next = s4_p_reg;
                    blue_next  = s4_q_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv3)
            begin
                s3_valid_reg <= hue_valid;
            end
            if (adv4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (adv5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            s3_region_reg <= hue_info.region;
            s3_pterm_reg  <= rhr_pkg::CHAN_MAX - saturation_reg;
            s3_qterm_reg  <= rhr_pkg::CHAN_MAX - sq_prod[15:8];
            s3_tterm_reg  <= rhr_pkg::CHAN_MAX - st_prod[15:8];
        end
        if (adv4)
        begin
            s4_region_reg <= s3_region_reg;
            s4_p_reg      <= vp_prod[15:8];
            s4_q_reg      <= vq_prod[15:8];
            s4_t_reg      <= vt_prod[15:8];
        end
        if (adv5)
        begin
            green_reg <= green_next;
            red_reg   <= red_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign green     = green_reg;
    assign red       = red_reg;
    assign blue      = blue_reg;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for rainbow_hsv_to_rgb_top: pixel stream in, green/red/blue out.
// Depends on rhr_pkg and the RTL of rainbow_hsv_to_rgb_top; it needs nothing else.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CHAN_W      = rhr_pkg::CHAN_W;
    localparam int unsigned CFG_INDEX_W = rhr_pkg::CFG_INDEX_W;
    localparam int unsigned STRIP_LEN   = 16;
    localparam int unsigned PIPE_DEPTH  = 5;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned PHASES      = 10;
    localparam int unsigned PHASE_ITEMS = 150;
    localparam int unsigned MAX_REPORTS = 10;

    // Indexes outside the register list; writes to them must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [CHAN_W-1:0] step;
        logic [CHAN_W-1:0] led_index;
    } led_request_t;

    typedef struct packed {
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [CHAN_W-1:0]      step      = '0;
    logic [CHAN_W-1:0]      led_index = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [CHAN_W-1:0]      green;
    logic [CHAN_W-1:0]      red;
    logic [CHAN_W-1:0]      blue;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CHAN_W-1:0]      cfg_data  = '0;

    led_request_t      pending_leds[$];
    pixel_t            expected_pixels[$];
    led_request_t      next_led;
    pixel_t            want_pixel;
    pixel_t            got_pixel;
    logic [CHAN_W-1:0] sat_level;
    logic [CHAN_W-1:0] bri_level;
    bit                idle_on;
    int unsigned       gap_left;
    int unsigned       stall_left;
    int unsigned       pixels_sent;
    int unsigned       pixels_checked;
    int unsigned       mismatches;
    int unsigned       reg_writes;
    int unsigned       cycle_count;

    rainbow_hsv_to_rgb_top #(
        .STRIP_LEN (STRIP_LEN)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .step      (step),
        .led_index (led_index),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .green     (green),
        .red       (red),
        .blue      (blue),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hue from step and LED position, then the six-region integer HSV conversion.
    function automatic pixel_t rainbow_pixel(input logic [CHAN_W-1:0] st,
                                             input logic [CHAN_W-1:0] pos);
        int unsigned      hue;
        int unsigned      frac;
        int unsigned      s;
        int unsigned      v;
        int unsigned      p;
        int unsigned      q;
        int unsigned      t;
        rhr_pkg::region_t region;
        pixel_t           px;
        hue = (int'(st) + (int'(pos) * 256) / STRIP_LEN) & 'hFF;
        s   = sat_level;
        v   = bri_level;
        if (s == 0)
        begin
            px = '{green: v[7:0], red: v[7:0], blue: v[7:0]};
        end
        else
        begin
            region = rhr_pkg::region_t'(hue / int'(rhr_pkg::REGION_SPAN));
            frac   = (hue - (hue / int'(rhr_pkg::REGION_SPAN)) * int'(rhr_pkg::REGION_SPAN))
                     * 6;
            p      = (v * (255 - s)) >> 8;
            q      = (v * (255 - ((s * frac) >> 8))) >> 8;
            t      = (v * (255 - ((s * (255 - frac)) >> 8))) >> 8;
            case (region)
                rhr_pkg::REGION_RED_YELLOW:
                    px = '{green: t[7:0], red: v[7:0], blue: p[7:0]};
                rhr_pkg::REGION_YELLOW_GREEN:
                    px = '{green: v[7:0], red: q[7:0], blue: p[7:0]};
                rhr_pkg::REGION_GREEN_CYAN:
                    px = '{green: v[7:0], red: p[7:0], blue: t[7:0]};
                rhr_pkg::REGION_CYAN_BLUE:
                    px = '{green: q[7:0], red: p[7:0], blue: v[7:0]};
                rhr_pkg::REGION_BLUE_MAGENTA:
                    px = '{green: p[7:0], red: t[7:0], blue: v[7:0]};
                default:
                    px = '{green: p[7:0], red: v[7:0], blue: q[7:0]};
            endcase
        end
        return px;
    endfunction

    // Driver: one transaction per free slot, with random idle bursts between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            step      <= '0;
            led_index <= '0;
            gap_left  = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_pixels.push_back(rainbow_pixel(step, led_index));
                pixels_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left--;
                end
                else if (pending_leds.size() > 0)
                begin
                    next_led  = pending_leds.pop_front();
                    in_valid  <= 1'b1;
                    step      <= next_led.step;
                    led_index <= next_led.led_index;
                    if (idle_on && $urandom_range(0, 9) == 0)
                        gap_left = $urandom_range(1, 14);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each accepted pixel with the oldest prediction and stalls at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_pixel = '{green: green, red: red, blue: blue};
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected pixel g=%0d r=%0d b=%0d",
                                 green, red, blue);
                end
                else
                begin
                    want_pixel = expected_pixels.pop_front();
                    pixels_checked++;
                    if (got_pixel !== want_pixel)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"pixel %0d: expected g=%0d r=%0d b=%0d, ",
                                      "got g=%0d r=%0d b=%0d"},
                                     pixels_checked, want_pixel.green, want_pixel.red,
                                     want_pixel.blue, green, red, blue);
                    end
                end
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 14);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CHAN_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == rhr_pkg::CFG_SATURATION)
            sat_level = val;
        else if (idx == rhr_pkg::CFG_BRIGHTNESS)
            bri_level = val;
    endtask

    // The queue is filled away from the rising edge so the driver never races with it.
    task automatic queue_led(input logic [CHAN_W-1:0] st, input logic [CHAN_W-1:0] pos);
        led_request_t req;
        req = '{step: st, led_index: pos};
        pending_leds.push_back(req);
    endtask

    // Holds off until every prediction is matched and the pipeline is empty.
    task automatic wait_idle();
        @(negedge clk);
        while (pending_leds.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    function automatic logic [CHAN_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return rhr_pkg::CHAN_MAX;
            2:       return 8'd1;
            default: return CHAN_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CHAN_W-1:0] pick_position();
        if ($urandom_range(0, 4) != 0)
            return CHAN_W'($urandom_range(0, STRIP_LEN - 1));
        return CHAN_W'($urandom_range(0, 255));
    endfunction

    initial
    begin
        int unsigned boundary_hues[12] = '{0, 42, 43, 85, 86, 128, 129, 171, 172, 214, 215, 255};
        sat_level      = rhr_pkg::SATURATION_RESET;
        bri_level      = rhr_pkg::BRIGHTNESS_RESET;
        idle_on        = 1'b1;
        pixels_sent    = 0;
        pixels_checked = 0;
        mismatches     = 0;
        reg_writes     = 0;
        cycle_count    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: every region edge, the top of the hue circle and positions past the strip.
        @(negedge clk);
        foreach (boundary_hues[i])
            queue_led(CHAN_W'(boundary_hues[i]), '0);
        queue_led(8'd255, 8'd15);
        queue_led(8'd0, 8'd16);
        queue_led(8'd0, 8'd128);
        queue_led(8'd255, 8'd255);
        wait_idle();

        // Zero saturation gives grey at the brightness level.
        write_reg(rhr_pkg::CFG_SATURATION, '0);
        @(negedge clk);
        queue_led(8'd17, 8'd3);
        queue_led(8'd200, 8'd9);
        wait_idle();

        write_reg(rhr_pkg::CFG_SATURATION, rhr_pkg::CHAN_MAX);
        write_reg(rhr_pkg::CFG_BRIGHTNESS, rhr_pkg::CHAN_MAX);
        @(negedge clk);
        queue_led(8'd10, 8'd0);
        queue_led(8'd100, 8'd5);
        queue_led(8'd230, 8'd0);
        wait_idle();

        // Writes to indexes past the list are dropped.
        write_reg(rhr_pkg::CFG_BRIGHTNESS, '0);
        write_reg(CFG_SPARE_2, 8'd77);
        write_reg(CFG_SPARE_3, 8'd200);
        @(negedge clk);
        queue_led(8'd60, 8'd2);
        queue_led(8'd150, 8'd11);
        wait_idle();

        for (int unsigned phase = 0; phase < PHASES; phase++)
        begin
            write_reg(rhr_pkg::CFG_SATURATION, pick_level());
            write_reg(rhr_pkg::CFG_BRIGHTNESS, pick_level());
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                          CHAN_W'($urandom_range(0, 255)));
            @(negedge clk);
            if (phase == PHASES - 1)
                idle_on = 1'b0;
            for (int unsigned n = 0; n < PHASE_ITEMS; n++)
                queue_led(CHAN_W'($urandom_range(0, 255)), pick_position());
            wait_idle();
        end

        repeat (PIPE_DEPTH * 4) @(posedge clk);
        if (expected_pixels.size() != 0)
        begin
            $display("%0d predicted pixels never arrived", expected_pixels.size());
            mismatches++;
        end
        $display("Sent %0d pixels and checked %0d across %0d register writes.",
                 pixels_sent, pixels_checked, reg_writes);
        $display("Mismatches: %0d.", mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rhr_pkg.sv
rtl/rhr_hue_stage.sv
rtl/rainbow_hsv_to_rgb_top.sv
test/tb.sv
